/* design/huffman_encode_bit_packer_top_macros.svh */
// assertion helpers used by the checker file
`ifndef HUFFMAN_ENCODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_ENCODE_BIT_PACKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while reset is applied
`define HEBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet while reset is applied
`define HEBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/hebp_pkg.sv */
`default_nettype none

package hebp_pkg;

  // field widths fixed by the item formats
  localparam int BYTE_BITS = 8;
  localparam int OP_W      = 2;
  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  // byte count per item: at most four at the largest supported code length
  localparam int CNT_W     = 3;

  // parameter defaults
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int TABLE_DEPTH_DEF  = 256;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last_of_run;
  } out_item_t;

  // table lookup result handed to the packer
  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // packer to byte emitter request
  typedef struct packed {
    logic             req;
    logic [CNT_W-1:0] count;
  } emit_ctl_t;

endpackage

`default_nettype wire

/* design/hebp_table.sv */
`default_nettype none

module hebp_table #(
  parameter int MAX_CODE_LEN = hebp_pkg::MAX_CODE_LEN_DEF,
  parameter int TABLE_DEPTH  = hebp_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire hebp_pkg::in_item_t item,
  output hebp_pkg::entry_t       entry
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = hebp_pkg::CODE_W + hebp_pkg::LEN_W;

  logic [ENT_W-1:0]              mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]        valid_r;
  logic [ENT_W-1:0]              rd_r;
  logic                          hit_r;
  logic [IDX_W-1:0]              idx;
  logic                          in_range;
  logic                          wr_en;
  logic [hebp_pkg::LEN_W-1:0]    len_m;
  logic [hebp_pkg::CODE_W-1:0]   code_m;

  assign idx      = item.symbol[IDX_W-1:0];
  assign in_range = {1'b0, item.symbol} < (hebp_pkg::SYM_W + 1)'(TABLE_DEPTH);
  assign wr_en    = accept && (item.operation == hebp_pkg::OP_LOAD) && in_range;

  // overlong codes are stored as no code, and only the low len bits are kept
  always_comb begin
    len_m = (item.code_length > hebp_pkg::LEN_W'(MAX_CODE_LEN)) ? '0 : item.code_length;
    if (len_m >= hebp_pkg::LEN_W'(hebp_pkg::CODE_W)) begin
      code_m = item.code_bits;
    end else begin
      code_m = item.code_bits &
               hebp_pkg::CODE_W'(((hebp_pkg::CODE_W + 1)'(1) << len_m) -
                                 (hebp_pkg::CODE_W + 1)'(1));
    end
  end

  // code table storage, registered read at item acceptance
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= {code_m, len_m};
    end
    if (accept) begin
      rd_r <= mem[idx];
    end
  end

  // per-entry valid bits, cleared at reset so unloaded entries read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[idx] <= 1'b1;
      end
      if (accept) begin
        hit_r <= in_range && valid_r[idx];
      end
    end
  end

  assign entry.hit  = hit_r;
  assign entry.code = rd_r[ENT_W-1:hebp_pkg::LEN_W];
  assign entry.len  = rd_r[hebp_pkg::LEN_W-1:0];

endmodule

`default_nettype wire

/* design/hebp_pack.sv */
`default_nettype none

module hebp_pack #(
  parameter int WORD_W = hebp_pkg::MAX_CODE_LEN_DEF + hebp_pkg::BYTE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [hebp_pkg::OP_W-1:0]   operation,
  input  wire hebp_pkg::entry_t            entry,
  input  wire logic                        em_free,
  output logic                             in_ready,
  output hebp_pkg::emit_ctl_t              emit_ctl,
  output logic [WORD_W-1:0]                emit_word
);

  localparam int TOT_W = hebp_pkg::LEN_W + 1;
  localparam int SH_W  = $clog2(WORD_W + 1);
  localparam int BB    = hebp_pkg::BYTE_BITS;

  logic                             s1_v_r, s1_v_nxt;
  logic [hebp_pkg::OP_W-1:0]        op_r;
  logic [BB-1:0]                    held_bits_r, held_bits_nxt;
  logic [2:0]                       held_cnt_r, held_cnt_nxt;

  logic [hebp_pkg::LEN_W-1:0]       len_eff;
  logic [TOT_W-1:0]                 total;
  logic [WORD_W-1:0]                acc;
  logic [WORD_W-1:0]                aligned;
  logic [WORD_W-1:0]                flush_word;
  logic [SH_W-1:0]                  sh;
  logic [hebp_pkg::CNT_W-1:0]       nb;
  logic [BB-1:0]                    pad_byte;
  logic [BB-1:0]                    keep_mask;
  logic                             needs_emit;
  logic                             s1_go;

  // append the looked-up code below the held bits
  assign len_eff    = (op_r == hebp_pkg::OP_ENCODE && entry.hit) ? entry.len : '0;
  assign total      = TOT_W'(held_cnt_r) + TOT_W'(len_eff);
  assign acc        = (WORD_W'(held_bits_r) << len_eff) | WORD_W'(entry.code);
  assign nb         = hebp_pkg::CNT_W'(total >> 3);
  assign keep_mask  = BB'((9'd1 << total[2:0]) - 9'd1);

  // left-justify the full bytes so the emitter shifts them out from the top
  assign sh         = SH_W'(WORD_W) - SH_W'(total);
  assign aligned    = acc << sh;

  // flush: held bits right-aligned, then the pad count byte
  assign pad_byte   = BB'(BB) - BB'(held_cnt_r);
  assign flush_word = WORD_W'({held_bits_r, pad_byte}) << (WORD_W - 2 * BB);

  always_comb begin
    case (op_r)
      hebp_pkg::OP_ENCODE: needs_emit = (nb != '0);
      hebp_pkg::OP_FLUSH:  needs_emit = 1'b1;
      default:             needs_emit = 1'b0;
    endcase
  end

  // the item leaves once the emitter can take its bytes
  assign s1_go    = s1_v_r && (!needs_emit || em_free);
  assign in_ready = !s1_v_r || s1_go;

  assign emit_ctl.req   = s1_go && needs_emit;
  assign emit_ctl.count = (op_r == hebp_pkg::OP_FLUSH) ? hebp_pkg::CNT_W'(2) : nb;
  assign emit_word      = (op_r == hebp_pkg::OP_FLUSH) ? flush_word : aligned;

  // next state of stage valid and held bits
  always_comb begin
    s1_v_nxt      = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    held_bits_nxt = held_bits_r;
    held_cnt_nxt  = held_cnt_r;
    if (s1_go) begin
      case (op_r)
        hebp_pkg::OP_ENCODE: begin
          if (len_eff != '0) begin
            held_cnt_nxt  = total[2:0];
            held_bits_nxt = acc[BB-1:0] & keep_mask;
          end
        end
        hebp_pkg::OP_FLUSH: begin
          held_cnt_nxt  = '0;
          held_bits_nxt = '0;
        end
        default: begin
          held_cnt_nxt  = held_cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      held_bits_r <= '0;
      held_cnt_r  <= '0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      held_bits_r <= held_bits_nxt;
      held_cnt_r  <= held_cnt_nxt;
    end
  end

  // operation follows the table read into this stage
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= operation;
    end
  end

endmodule

`default_nettype wire

/* design/hebp_emit.sv */
`default_nettype none

module hebp_emit #(
  parameter int WORD_W = hebp_pkg::MAX_CODE_LEN_DEF + hebp_pkg::BYTE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire hebp_pkg::emit_ctl_t   emit_ctl,
  input  wire logic [WORD_W-1:0]     emit_word,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output hebp_pkg::out_item_t        out_data,
  output logic                       em_free
);

  localparam int BB = hebp_pkg::BYTE_BITS;

  logic                         em_v_r, em_v_nxt;
  logic [hebp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]            word_r, word_nxt;
  logic                         last;

  assign last      = (cnt_r == hebp_pkg::CNT_W'(1));
  assign em_free   = !em_v_r || (out_ready && last);
  assign out_valid = em_v_r;
  assign out_data.out_byte    = word_r[WORD_W-1 -: BB];
  assign out_data.last_of_run = last;

  // load a new run, or shift out the next byte once the current one is taken
  always_comb begin
    em_v_nxt = em_v_r;
    cnt_nxt  = cnt_r;
    word_nxt = word_r;
    if (emit_ctl.req) begin
      em_v_nxt = 1'b1;
      cnt_nxt  = emit_ctl.count;
      word_nxt = emit_word;
    end else if (em_v_r && out_ready) begin
      if (last) begin
        em_v_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_r - hebp_pkg::CNT_W'(1);
        word_nxt = word_r << BB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      em_v_r <= em_v_nxt;
      cnt_r  <= cnt_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

/* design/huffman_encode_bit_packer_top.sv */
// Variable-length code encoder with byte packing.
// Input channel in_valid/in_ready/in_data carries load, encode and flush items.
// A load writes one code table entry and produces no output. An encode looks up
// its symbol and packs the code, first bit most significant; each completed byte
// goes out on out_valid/out_ready/out_data, last_of_run marking the item's last.
// A flush sends the held bits right-aligned, then a byte holding 8 minus the
// held count, and clears the held bits.
// An accepted item's table read and operation are registered into the lookup
// stage; its bytes load into the output stage once free. Throughput: one item
// per cycle while items produce at most one byte and the receiver does not
// stall; a multi-byte item holds the single-byte output stage until its last
// byte is taken, up to four bytes per encode at the default code length. The
// output stage is the limiting unit; the table is a single-port memory read
// once per item. Reset clears the held bits and every table valid bit, so all
// symbols read as having no code. When the receiver stalls, the current byte
// is held, an emitting item waits in the lookup stage and in_ready drops.
`default_nettype none

module huffman_encode_bit_packer_top #(
  parameter int MAX_CODE_LEN = hebp_pkg::MAX_CODE_LEN_DEF,
  parameter int TABLE_DEPTH  = hebp_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hebp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output hebp_pkg::out_item_t       out_data
);

  localparam int WORD_W = MAX_CODE_LEN + hebp_pkg::BYTE_BITS;

  logic                   accept;
  hebp_pkg::entry_t       entry;
  hebp_pkg::emit_ctl_t    emit_ctl;
  logic [WORD_W-1:0]      emit_word;
  logic                   em_free;

  assign accept = in_valid && in_ready;

  hebp_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .TABLE_DEPTH  (TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .entry  (entry)
  );

  hebp_pack #(
    .WORD_W (WORD_W)
  ) u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_data.operation),
    .entry     (entry),
    .em_free   (em_free),
    .in_ready  (in_ready),
    .emit_ctl  (emit_ctl),
    .emit_word (emit_word)
  );

  hebp_emit #(
    .WORD_W (WORD_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_ctl  (emit_ctl),
    .emit_word (emit_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .em_free   (em_free)
  );

endmodule

`default_nettype wire

/* design/hebp_checker.sv */
`default_nettype none
`include "huffman_encode_bit_packer_top_macros.svh"

module hebp_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire hebp_pkg::in_item_t   in_data,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire hebp_pkg::out_item_t  out_data
);

  // a stalled output byte stays presented and unchanged
  `HEBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output item changed while stalled")

  // a byte that is not the last of its run is followed by another
  `HEBP_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_data.last_of_run, out_valid, "run ended without last_of_run")

  // nothing is presented right after reset
  `HEBP_ASSERT_IMPL(a_rst_out, $rose(rst_n), !out_valid, "output valid right after reset")

  // the block takes an item right after reset
  `HEBP_ASSERT_IMPL(a_rst_rdy, $rose(rst_n), in_ready, "input not ready right after reset")

endmodule

bind huffman_encode_bit_packer_top hebp_checker u_hebp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  // operation code the block ignores
  localparam logic [hebp_pkg::OP_W-1:0] OP_RSVD = 2'd3;
  localparam int MAX_LEN = hebp_pkg::MAX_CODE_LEN_DEF;
  localparam int N_RANDOM = 260;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT = 150;
  localparam int DRAIN_AT = 200;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  hebp_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  hebp_pkg::out_item_t out_data;

  // directed stimulus row; n_want < 0 means the predictor supplies the bytes
  typedef struct {
    hebp_pkg::in_item_t item;
    int n_want;
    logic [31:0] want_bytes;
  } stim_row_t;

  stim_row_t directed [$];

  // predictor state: code table plus bit buffer
  logic [hebp_pkg::CODE_W-1:0] enc_code [256];
  logic [hebp_pkg::LEN_W-1:0] enc_len [256];
  logic [hebp_pkg::BYTE_BITS-1:0] held_bits_q;
  logic [hebp_pkg::CNT_W-1:0] held_cnt_q;
  hebp_pkg::out_item_t step_bytes [4];
  hebp_pkg::out_item_t pending_bytes [$];

  int errors = 0;
  int tx_count = 0;
  int idle_cycles = 0;

  huffman_encode_bit_packer_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predict the bytes one item causes and update the bit buffer
  function automatic int pack_item(input hebp_pkg::in_item_t item);
    int unsigned len;
    int unsigned total;
    int n;
    logic [63:0] acc;
    n = 0;
    case (item.operation)
      hebp_pkg::OP_LOAD: begin
        len = (item.code_length > MAX_LEN) ? 0 : item.code_length;
        enc_len[item.symbol] = hebp_pkg::LEN_W'(len);
        enc_code[item.symbol] =
          hebp_pkg::CODE_W'(64'(item.code_bits) & ((64'd1 << len) - 64'd1));
      end
      hebp_pkg::OP_ENCODE: begin
        len = enc_len[item.symbol];
        if (len != 0) begin
          total = held_cnt_q + len;
          acc = (64'(held_bits_q) << len) | 64'(enc_code[item.symbol]);
          while (total >= hebp_pkg::BYTE_BITS) begin
            total -= hebp_pkg::BYTE_BITS;
            step_bytes[n].out_byte = 8'(acc >> total);
            step_bytes[n].last_of_run = 1'b0;
            n++;
          end
          held_cnt_q = hebp_pkg::CNT_W'(total);
          held_bits_q = 8'(acc) & ((8'd1 << total) - 8'd1);
          if (n > 0) begin
            step_bytes[n-1].last_of_run = 1'b1;
          end
        end
      end
      hebp_pkg::OP_FLUSH: begin
        step_bytes[0].out_byte = held_bits_q;
        step_bytes[0].last_of_run = 1'b0;
        step_bytes[1].out_byte = 8'(hebp_pkg::BYTE_BITS - held_cnt_q);
        step_bytes[1].last_of_run = 1'b1;
        held_bits_q = '0;
        held_cnt_q = '0;
        n = 2;
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic void add_row(input logic [hebp_pkg::OP_W-1:0] op,
                                  input logic [hebp_pkg::SYM_W-1:0] sym,
                                  input logic [hebp_pkg::CODE_W-1:0] code,
                                  input logic [hebp_pkg::LEN_W-1:0] len, input int n_want,
                                  input logic [31:0] want_bytes);
    stim_row_t r;
    r.item.operation = op;
    r.item.symbol = sym;
    r.item.code_bits = code;
    r.item.code_length = len;
    r.n_want = n_want;
    r.want_bytes = want_bytes;
    directed = {directed, r};
  endfunction

  // random item: mostly loads and encodes over a small symbol pool
  function automatic hebp_pkg::in_item_t rand_item();
    hebp_pkg::in_item_t it;
    int pick;
    it.code_bits = $urandom;
    it.code_length = hebp_pkg::LEN_W'($urandom_range(0, 63));
    it.symbol = hebp_pkg::SYM_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.operation = hebp_pkg::OP_LOAD;
      if (pick < 15) begin
        it.symbol = {$urandom_range(0, 1) ? 4'hF : 4'h0, 4'($urandom_range(0, 15))};
        it.code_length = hebp_pkg::LEN_W'($urandom_range(1, MAX_LEN));
      end
    end else if (pick < 88) begin
      it.operation = hebp_pkg::OP_ENCODE;
      if (pick < 82) begin
        it.symbol = {$urandom_range(0, 1) ? 4'hF : 4'h0, 4'($urandom_range(0, 15))};
      end
    end else if (pick < 97) begin
      it.operation = hebp_pkg::OP_FLUSH;
    end else begin
      it.operation = OP_RSVD;
    end
    return it;
  endfunction

  // offer one item, then record what it should produce
  task automatic send_item(input hebp_pkg::in_item_t item, input int n_want,
                           input logic [31:0] want_bytes);
    int gap;
    int n;
    hebp_pkg::out_item_t b;
    gap = ((tx_count / 24) % 3 == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tx_count++;
    n = pack_item(item);
    if (n_want >= 0) begin
      for (int k = 0; k < n_want; k++) begin
        b.out_byte = want_bytes[31-8*k -: 8];
        b.last_of_run = (k == n_want - 1);
        pending_bytes = {pending_bytes, b};
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        pending_bytes = {pending_bytes, step_bytes[k]};
      end
    end
  endtask

  // stimulus: reset, directed table, random items, drain
  initial begin
    hebp_pkg::in_item_t it;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    for (int s = 0; s < 256; s++) begin
      enc_code[s] = '0;
      enc_len[s] = '0;
    end
    held_bits_q = '0;
    held_cnt_q = '0;

    // empty flush, missing codes, ignored operation
    add_row(hebp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, 2, 32'h0008_0000);
    add_row(hebp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 0, 32'h0);
    add_row(OP_RSVD, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 0, 32'h0);
    // one full byte, then the longest code
    add_row(hebp_pkg::OP_LOAD, 8'h41, 32'hFFFF_FFFF, 6'd8, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h41, 32'h0, 6'd0, 1, 32'hFF00_0000);
    add_row(hebp_pkg::OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0, 4, 32'hFFFF_FFFF);
    // codes too long leave the entry empty
    add_row(hebp_pkg::OP_LOAD, 8'h01, 32'hAAAA_AAAA, 6'd33, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h01, 32'h0, 6'd0, 0, 32'h0);
    add_row(hebp_pkg::OP_LOAD, 8'h02, 32'h5555_5555, 6'h3F, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h02, 32'h0, 6'd0, 0, 32'h0);
    // upper code bits dropped on load, partial byte flushed
    add_row(hebp_pkg::OP_LOAD, 8'h03, 32'hFFFF_FFFD, 6'd3, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h03, 32'h0, 6'd0, 0, 32'h0);
    add_row(hebp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, 2, 32'h0505_0000);
    // mixed alignments checked by the predictor
    add_row(hebp_pkg::OP_LOAD, 8'h04, 32'h0000_0001, 6'd1, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h04, 32'h0, 6'd0, -1, 32'h0);
    add_row(hebp_pkg::OP_LOAD, 8'h05, 32'h1234_5678, 6'd32, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h05, 32'h0, 6'd0, -1, 32'h0);
    add_row(hebp_pkg::OP_LOAD, 8'h06, 32'hFFFF_FFE0, 6'd5, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h06, 32'h0, 6'd0, -1, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h03, 32'h0, 6'd0, -1, 32'h0);
    add_row(hebp_pkg::OP_LOAD, 8'h80, 32'h0000_007F, 6'd7, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h80, 32'h0, 6'd0, -1, 32'h0);
    // explicit empty entry, then flush twice
    add_row(hebp_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0, 0, 32'h0);
    add_row(hebp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0, 0, 32'h0);
    add_row(hebp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, -1, 32'h0);
    add_row(hebp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0, 2, 32'h0008_0000);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_item(directed[i].item, directed[i].n_want, directed[i].want_bytes);
    end

    // fill the symbol pool, then random traffic
    for (int s = 0; s < 32; s++) begin
      it.operation = hebp_pkg::OP_LOAD;
      it.symbol = {s[4] ? 4'hF : 4'h0, 4'(s)};
      it.code_bits = $urandom;
      it.code_length = hebp_pkg::LEN_W'($urandom_range(1, MAX_LEN));
      send_item(it, -1, 32'h0);
    end
    for (int r = 0; r < N_RANDOM; r++) begin
      if (r == DRAIN_AT) begin
        // let the block run dry once before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
      end
      it = rand_item();
      send_item(it, -1, 32'h0);
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[huffman_encode_bit_packer_top] OK");
    end else begin
      $display("[huffman_encode_bit_packer_top] ERROR");
    end
    $finish;
  end

  // receiver: random stalls, stretches of none, one long hold-off
  initial begin
    int got;
    int wait_cycles;
    bit held_off;
    got = 0;
    held_off = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      wait_cycles = ((got / 32) % 3 == 1) ? 0 : $urandom_range(0, 15);
      if (got >= HOLD_OFF_AT && !held_off) begin
        held_off = 1'b1;
        wait_cycles = HOLD_OFF_CYCLES;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
    end
  end

  // compare each accepted byte with the oldest expectation
  always @(posedge clk) begin
    hebp_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected item, expected none, got byte %h last %b",
                 $time, out_data.out_byte, out_data.last_of_run);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h, got %h", $time, want.out_byte,
                   out_data.out_byte);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run,
                   out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[huffman_encode_bit_packer_top] ERROR");
      $finish;
    end
  end

endmodule
